@@ rtl/pwr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwr_pkg
// shared types and constants of the particle weight resampler
// ----------------------------------------------------------------------------
package pwr_pkg;

  localparam int MAX_PARTICLES_DEF = 1024;

  localparam int CFG_W      = 25;
  localparam int CFG_IDX_W  = 2;
  localparam int COUNT_W    = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_PARTICLE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_FLOOR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIFORM_WEIGHT = 2'd2;

  localparam logic [COUNT_W-1:0] PARTICLE_COUNT_RST = 11'd1024;
  localparam logic [CFG_W-1:0]   WEIGHT_FLOOR_RST   = 25'd2;
  localparam logic [CFG_W-1:0]   UNIFORM_WEIGHT_RST = 25'd16384;

  localparam logic [COUNT_W-1:0] COUNT_SAT = 11'd2047;
  localparam logic [31:0]        SEQ_HALF  = 32'h7FFF_FFFF;

  localparam logic [1:0] CMD_POSE   = 2'd0;
  localparam logic [1:0] CMD_WEIGHT = 2'd1;
  localparam logic [1:0] CMD_DRAW   = 2'd2;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_SELECT = 2'd1;
  localparam logic [1:0] KIND_MEAN   = 2'd2;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_STALE      = 2'd1;
  localparam logic [1:0] ST_SIZE       = 2'd2;
  localparam logic [1:0] ST_UNEXPECTED = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POSE,
    S_BAD,
    S_WMUL,
    S_WACC,
    S_DHI,
    S_DLO,
    S_DTHR,
    S_SCAN_CHK,
    S_SCAN_ACC,
    S_PREAD,
    S_PUSE,
    S_DIV,
    S_MEAN
  } state_t;

endpackage
`default_nettype wire

@@ rtl/particle_weight_resampler_unit.sv @@
// pose write: result from S_POSE; weight element: product registered in S_WMUL, result from S_WACC
// draw: threshold from S_DHI, S_DLO and S_DTHR, then j, the selected index, set by the weight scan
// that reads one stored weight per S_SCAN_CHK/S_SCAN_ACC pair, then S_PREAD and S_PUSE
// last draw then runs the bit-serial mean divider over the three pose components
// one transaction in work at a time; in_ready is high only when idle
// synchronous reset clears control state at once; no memory clearing pass
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// particle_weight_resampler_unit
// weight normalization, multinomial resampling and mean pose of a particle set
// ----------------------------------------------------------------------------
module particle_weight_resampler_unit #(
  parameter int MAX_PARTICLES = pwr_pkg::MAX_PARTICLES_DEF
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_write,
  input  wire [pwr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [pwr_pkg::CFG_W-1:0]     cfg_data,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire [1:0]                    command,
  input  wire [9:0]                    slot,
  input  wire signed [31:0]            pose_x,
  input  wire signed [31:0]            pose_y,
  input  wire signed [15:0]            pose_heading,
  input  wire [31:0]                   likelihood,
  input  wire [31:0]                   batch_seq,
  input  wire                          final_item,
  input  wire [23:0]                   draw,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [1:0]                   kind,
  output logic [1:0]                   status,
  output logic [9:0]                   new_slot,
  output logic [9:0]                   source_slot,
  output logic signed [31:0]           out_x,
  output logic signed [31:0]           out_y,
  output logic signed [15:0]           out_heading,
  output logic                         run_end
);

  localparam int IW    = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int CW    = $clog2(MAX_PARTICLES + 1);
  localparam int SW    = 32 + IW;
  localparam int ACC_W = 32 + IW;
  localparam int DCW   = $clog2(ACC_W);

  pwr_pkg::state_t state, state_next;

  // configuration
  logic [pwr_pkg::COUNT_W-1:0] particle_count;
  logic [pwr_pkg::CFG_W-1:0]   weight_floor;
  logic [pwr_pkg::CFG_W-1:0]   uniform_weight;

  // latched transaction
  logic [9:0]         slot_q;
  logic [79:0]        pose_q;
  logic [31:0]        lik_q;
  logic [31:0]        seq_q;
  logic               fin_q;
  logic [23:0]        draw_q;

  // filter state
  logic               active_bank;
  logic [SW-1:0]      weight_sum;
  logic [pwr_pkg::COUNT_W-1:0] weight_counter;
  logic [CW-1:0]      draw_counter;
  logic               pending;
  logic [31:0]        set_sequence;
  logic [31:0]        accepted_sequence;
  logic signed [ACC_W-1:0] acc [3];
  logic signed [ACC_W-1:0] acc_x_sum;

  // memories
  logic [79:0]        pose_mem [2*MAX_PARTICLES];
  logic [31:0]        weight_mem [MAX_PARTICLES];
  logic [79:0]        pose_rd;
  logic [31:0]        weight_rd;

  // shared multiplier and scan
  logic [63:0]        prod;
  logic [31:0]        mul_a, mul_b;
  logic               mul_en;
  logic [SW-1:0]      thr_hold;
  logic [SW-1:0]      thr;
  logic [SW-1:0]      cum;
  logic [SW-1:0]      cum_sum;
  logic [IW-1:0]      j;

  // divider
  logic [1:0]         div_comp;
  logic [DCW-1:0]     div_cnt;
  logic [CW-1:0]      rem;
  logic [ACC_W-1:0]   dvd;
  logic               div_neg;
  logic [CW:0]        div_t;
  logic               div_bit;
  logic [ACC_W-1:0]   dvd_next;
  logic [ACC_W-1:0]   quo;
  logic signed [31:0] mean [3];

  // decode
  logic               ofree;
  logic               fire;
  logic [CW-1:0]      n_eff;
  logic               last_j;
  logic               last_draw;
  logic               hit;
  logic [31:0]        w_sat;
  logic [31:0]        w;
  logic [pwr_pkg::COUNT_W-1:0] wcnt_inc;
  logic               fresh;
  logic               size_ok;
  logic [1:0]         w_status;
  logic               slot_ok;
  logic               wmem_rd_en;
  logic               pmem_rd_en;
  logic               div_last;
  logic [IW:0]        pose_raddr;

  always_comb begin
    if (particle_count == '0) begin
      n_eff = CW'(1);
    end else if (32'(particle_count) > 32'(MAX_PARTICLES)) begin
      n_eff = CW'(MAX_PARTICLES);
    end else begin
      n_eff = CW'(particle_count);
    end
  end

  assign ofree     = !out_valid || out_ready;
  assign in_ready  = (state == pwr_pkg::S_IDLE);
  assign last_j    = !((32'(j) + 32'd1) < 32'(n_eff));
  assign last_draw = !((32'(draw_counter) + 32'd1) < 32'(n_eff));
  assign cum_sum   = cum + SW'(weight_rd);
  assign hit       = cum_sum > thr;
  assign slot_ok   = 32'(slot_q) < 32'(MAX_PARTICLES);
  assign div_last  = (32'(div_cnt) == 32'(ACC_W - 1));
  assign div_t     = {rem, dvd[ACC_W-1]};
  assign div_bit   = div_t >= {1'b0, n_eff};
  assign dvd_next  = {dvd[ACC_W-2:0], div_bit};
  assign quo       = div_neg ? (~dvd_next + 1'b1) : dvd_next;
  assign pose_raddr = {active_bank, j};
  assign acc_x_sum = acc[0] + ACC_W'($signed(pose_rd[79:48]));

  // weight arithmetic and batch checks
  always_comb begin
    w_sat = (prod[63:56] != 8'd0) ? 32'hFFFF_FFFF : prod[55:24];
    w     = (w_sat < 32'(weight_floor)) ? 32'(weight_floor) : w_sat;
    wcnt_inc = (weight_counter < pwr_pkg::COUNT_SAT) ? weight_counter + 1'b1
                                                     : weight_counter;
    fresh = (seq_q > accepted_sequence) ||
            (accepted_sequence >= pwr_pkg::SEQ_HALF && seq_q < pwr_pkg::SEQ_HALF);
    size_ok = (particle_count != '0) &&
              (32'(particle_count) <= 32'(MAX_PARTICLES)) &&
              (wcnt_inc == particle_count);
    if (!fin_q || (fresh && size_ok)) begin
      w_status = pwr_pkg::ST_OK;
    end else if (!fresh) begin
      w_status = pwr_pkg::ST_STALE;
    end else begin
      w_status = pwr_pkg::ST_SIZE;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      pwr_pkg::S_IDLE: begin
        if (in_valid) begin
          case (command)
            pwr_pkg::CMD_POSE:   state_next = pending ? pwr_pkg::S_BAD : pwr_pkg::S_POSE;
            pwr_pkg::CMD_WEIGHT: state_next = pending ? pwr_pkg::S_BAD : pwr_pkg::S_WMUL;
            pwr_pkg::CMD_DRAW:   state_next = pending ? pwr_pkg::S_DHI : pwr_pkg::S_BAD;
            default:             state_next = pwr_pkg::S_BAD;
          endcase
        end
      end
      pwr_pkg::S_POSE, pwr_pkg::S_BAD, pwr_pkg::S_WACC, pwr_pkg::S_MEAN: begin
        if (ofree) state_next = pwr_pkg::S_IDLE;
      end
      pwr_pkg::S_WMUL:     state_next = pwr_pkg::S_WACC;
      pwr_pkg::S_DHI:      state_next = pwr_pkg::S_DLO;
      pwr_pkg::S_DLO:      state_next = pwr_pkg::S_DTHR;
      pwr_pkg::S_DTHR:     state_next = pwr_pkg::S_SCAN_CHK;
      pwr_pkg::S_SCAN_CHK: state_next = last_j ? pwr_pkg::S_PREAD : pwr_pkg::S_SCAN_ACC;
      pwr_pkg::S_SCAN_ACC: state_next = hit ? pwr_pkg::S_PREAD : pwr_pkg::S_SCAN_CHK;
      pwr_pkg::S_PREAD:    state_next = pwr_pkg::S_PUSE;
      pwr_pkg::S_PUSE: begin
        if (ofree) state_next = last_draw ? pwr_pkg::S_DIV : pwr_pkg::S_IDLE;
      end
      pwr_pkg::S_DIV: begin
        if (div_last && div_comp == 2'd2) state_next = pwr_pkg::S_MEAN;
      end
      default: state_next = pwr_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    fire       = 1'b0;
    mul_en     = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    wmem_rd_en = 1'b0;
    pmem_rd_en = 1'b0;
    case (state)
      pwr_pkg::S_POSE, pwr_pkg::S_BAD, pwr_pkg::S_WACC,
      pwr_pkg::S_PUSE, pwr_pkg::S_MEAN: begin
        fire = ofree;
      end
      pwr_pkg::S_WMUL: begin
        mul_en = 1'b1;
        mul_a  = 32'(uniform_weight);
        mul_b  = lik_q;
      end
      pwr_pkg::S_DHI: begin
        mul_en = 1'b1;
        mul_a  = 32'(draw_q);
        mul_b  = 32'(weight_sum[SW-1:24]);
      end
      pwr_pkg::S_DLO: begin
        mul_en = 1'b1;
        mul_a  = 32'(draw_q);
        mul_b  = 32'(weight_sum[23:0]);
      end
      pwr_pkg::S_SCAN_CHK: wmem_rd_en = !last_j;
      pwr_pkg::S_PREAD:    pmem_rd_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pwr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      particle_count <= pwr_pkg::PARTICLE_COUNT_RST;
      weight_floor   <= pwr_pkg::WEIGHT_FLOOR_RST;
      uniform_weight <= pwr_pkg::UNIFORM_WEIGHT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        pwr_pkg::CFG_PARTICLE_COUNT: particle_count <= cfg_data[pwr_pkg::COUNT_W-1:0];
        pwr_pkg::CFG_WEIGHT_FLOOR:   weight_floor   <= cfg_data;
        pwr_pkg::CFG_UNIFORM_WEIGHT: uniform_weight <= cfg_data;
        default: ;
      endcase
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (fire && state == pwr_pkg::S_POSE && slot_ok) begin
      pose_mem[{active_bank, IW'(slot_q)}] <= pose_q;
    end else if (fire && state == pwr_pkg::S_PUSE) begin
      pose_mem[{~active_bank, IW'(draw_counter)}] <= pose_rd;
    end
    if (pmem_rd_en) pose_rd <= pose_mem[pose_raddr];
  end

  always_ff @(posedge clk) begin
    if (fire && state == pwr_pkg::S_WACC &&
        32'(weight_counter) < 32'(MAX_PARTICLES)) begin
      weight_mem[IW'(weight_counter)] <= w;
    end
    if (wmem_rd_en) weight_rd <= weight_mem[j];
  end

  // payload and datapath
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      slot_q <= slot;
      pose_q <= {pose_x, pose_y, pose_heading};
      lik_q  <= likelihood;
      seq_q  <= batch_seq;
      fin_q  <= final_item;
      draw_q <= draw;
    end
    if (mul_en) prod <= mul_a * mul_b;
    if (state == pwr_pkg::S_DLO) thr_hold <= prod[SW-1:0];
    if (state == pwr_pkg::S_DTHR) begin
      thr <= thr_hold + SW'(prod[47:24]);
      cum <= '0;
      j   <= '0;
    end
    if (state == pwr_pkg::S_SCAN_ACC) begin
      cum <= cum_sum;
      if (!hit) j <= j + 1'b1;
    end
    if (fire && state == pwr_pkg::S_PUSE && last_draw) begin
      div_comp <= 2'd0;
      div_cnt  <= '0;
      rem      <= '0;
      div_neg  <= acc_x_sum[ACC_W-1];
      dvd      <= acc_x_sum[ACC_W-1] ? ACC_W'(-acc_x_sum) : ACC_W'(acc_x_sum);
    end
    if (state == pwr_pkg::S_DIV) begin
      if (div_last) begin
        mean[div_comp] <= 32'(quo);
        if (div_comp != 2'd2) begin
          div_comp <= div_comp + 1'b1;
          div_cnt  <= '0;
          rem      <= '0;
          div_neg  <= acc[div_comp + 1'b1][ACC_W-1];
          dvd      <= acc[div_comp + 1'b1][ACC_W-1] ? ACC_W'(-acc[div_comp + 1'b1])
                                                    : ACC_W'(acc[div_comp + 1'b1]);
        end
      end else begin
        div_cnt <= div_cnt + 1'b1;
        rem     <= div_bit ? CW'(div_t - {1'b0, n_eff}) : CW'(div_t);
        dvd     <= dvd_next;
      end
    end
  end

  // filter control state
  always_ff @(posedge clk) begin
    if (rst) begin
      active_bank       <= 1'b0;
      weight_sum        <= '0;
      weight_counter    <= '0;
      draw_counter      <= '0;
      pending           <= 1'b0;
      set_sequence      <= '0;
      accepted_sequence <= '0;
      for (int k = 0; k < 3; k++) acc[k] <= '0;
    end else if (fire) begin
      case (state)
        pwr_pkg::S_POSE: begin
          if (fin_q) set_sequence <= set_sequence + 1'b1;
        end
        pwr_pkg::S_WACC: begin
          if (fin_q) begin
            weight_counter <= '0;
            if (w_status == pwr_pkg::ST_OK) begin
              weight_sum   <= weight_sum + SW'(w);
              pending      <= 1'b1;
              draw_counter <= '0;
              for (int k = 0; k < 3; k++) acc[k] <= '0;
            end else begin
              weight_sum <= '0;
            end
          end else begin
            weight_sum     <= weight_sum + SW'(w);
            weight_counter <= wcnt_inc;
          end
        end
        pwr_pkg::S_PUSE: begin
          acc[0] <= acc_x_sum;
          acc[1] <= acc[1] + ACC_W'($signed(pose_rd[47:16]));
          acc[2] <= acc[2] + ACC_W'($signed(pose_rd[15:0]));
          if (!last_draw) draw_counter <= draw_counter + 1'b1;
        end
        pwr_pkg::S_MEAN: begin
          active_bank       <= ~active_bank;
          pending           <= 1'b0;
          draw_counter      <= '0;
          weight_sum        <= '0;
          accepted_sequence <= set_sequence + 1'b1;
          set_sequence      <= set_sequence + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      kind        <= pwr_pkg::KIND_STATUS;
      status      <= pwr_pkg::ST_OK;
      new_slot    <= '0;
      source_slot <= '0;
      out_x       <= '0;
      out_y       <= '0;
      out_heading <= '0;
      run_end     <= 1'b1;
      case (state)
        pwr_pkg::S_BAD:  status <= pwr_pkg::ST_UNEXPECTED;
        pwr_pkg::S_WACC: status <= w_status;
        pwr_pkg::S_PUSE: begin
          kind        <= pwr_pkg::KIND_SELECT;
          new_slot    <= 10'(draw_counter);
          source_slot <= 10'(j);
          out_x       <= pose_rd[79:48];
          out_y       <= pose_rd[47:16];
          out_heading <= pose_rd[15:0];
          run_end     <= !last_draw;
        end
        pwr_pkg::S_MEAN: begin
          kind        <= pwr_pkg::KIND_MEAN;
          out_x       <= mean[0];
          out_y       <= mean[1];
          out_heading <= mean[2][15:0];
        end
        default: ;
      endcase
    end
  end

  // checks
  a_pending_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(pending) |-> $past(state) == pwr_pkg::S_MEAN)
    else $error("pending cleared outside mean result");

  a_draw_bound: assert property (@(posedge clk) disable iff (rst)
    32'(draw_counter) < 32'(MAX_PARTICLES))
    else $error("draw counter beyond store");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == pwr_pkg::S_SCAN_ACC |-> (32'(j) + 32'd1) < 32'(n_eff))
    else $error("scan read beyond particle count");

  a_mean_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == pwr_pkg::KIND_MEAN |-> run_end)
    else $error("mean pose without run end");

  a_draw_only_pending: assert property (@(posedge clk) disable iff (rst)
    state == pwr_pkg::S_DHI |-> pending)
    else $error("draw work while not armed");

endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench of the particle weight resampler: pose writes, weight
// batches and resample draws go through a bursty driver, the receiver stalls and a
// monitor compares every result with a behavioral prediction of the block
// ----------------------------------------------------------------------------
module tb;
  import pwr_pkg::*;

  localparam int NMAX = MAX_PARTICLES_DEF;
  localparam int IDLE_LIMIT = 60000;

  typedef struct {
    logic [1:0]         command;
    logic [9:0]         slot;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [15:0] h;
    logic [31:0]        lik;
    logic [31:0]        seq;
    logic               fin;
    logic [23:0]        draw;
  } item_t;

  typedef struct {
    logic [1:0]         kind;
    logic [1:0]         status;
    logic [9:0]         new_slot;
    logic [9:0]         source_slot;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [15:0] h;
    logic               run_end;
  } result_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [15:0] h;
  } pose_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] command = '0;
  logic [9:0] slot = '0;
  logic signed [31:0] pose_x = '0;
  logic signed [31:0] pose_y = '0;
  logic signed [15:0] pose_heading = '0;
  logic [31:0] likelihood = '0;
  logic [31:0] batch_seq = '0;
  logic final_item = 1'b0;
  logic [23:0] draw = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] kind;
  logic [1:0] status;
  logic [9:0] new_slot;
  logic [9:0] source_slot;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [15:0] out_heading;
  logic run_end;

  always #2 clk = ~clk;

  particle_weight_resampler_unit DUT (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .slot(slot), .pose_x(pose_x), .pose_y(pose_y),
    .pose_heading(pose_heading), .likelihood(likelihood), .batch_seq(batch_seq),
    .final_item(final_item), .draw(draw),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .status(status), .new_slot(new_slot), .source_slot(source_slot),
    .out_x(out_x), .out_y(out_y), .out_heading(out_heading), .run_end(run_end)
  );

  // predicted block state
  pose_t       bank [2][NMAX];
  logic [31:0] wstore [NMAX];
  logic        act_bank = 1'b0;
  logic [63:0] wsum = '0;
  int unsigned wcount = 0;
  int unsigned dcount = 0;
  logic        armed = 1'b0;
  logic [31:0] set_seq = '0;
  logic [31:0] acc_seq = '0;
  longint      mean_acc [3];
  logic [10:0] cfg_count = PARTICLE_COUNT_RST;
  logic [24:0] cfg_floor = WEIGHT_FLOOR_RST;
  logic [24:0] cfg_uniform = UNIFORM_WEIGHT_RST;

  item_t   pending_items [$];
  result_t expected_results [$];
  item_t   cur_item;
  int      errors = 0;
  int      txn_in = 0;
  int      txn_out = 0;
  int      resamples = 0;
  int      burst_left = 0;
  int      gap_left = 0;
  int      hold_left = 0;
  int      idle_cycles = 0;

  function automatic result_t status_result(logic [1:0] st);
    result_t r;
    r = '{KIND_STATUS, st, 10'd0, 10'd0, 32'sd0, 32'sd0, 16'sd0, 1'b1};
    return r;
  endfunction

  task automatic predict_item(item_t it);
    logic [63:0] w;
    logic [63:0] thr;
    logic [63:0] cum;
    logic [1:0]  st;
    logic        fresh;
    logic        hit;
    int unsigned n;
    int unsigned j;
    pose_t       p;
    result_t     r;
    st = ST_OK;
    case (it.command)
      CMD_POSE: begin
        if (armed) begin
          expected_results.push_back(status_result(ST_UNEXPECTED));
        end else begin
          bank[act_bank][it.slot] = '{it.x, it.y, it.h};
          if (it.fin) set_seq = set_seq + 1;
          expected_results.push_back(status_result(ST_OK));
        end
      end
      CMD_WEIGHT: begin
        if (armed) begin
          expected_results.push_back(status_result(ST_UNEXPECTED));
        end else begin
          w = (64'(cfg_uniform) * 64'(it.lik)) >> 24;
          if (w > 64'hFFFF_FFFF) w = 64'hFFFF_FFFF;
          if (w < 64'(cfg_floor)) w = 64'(cfg_floor);
          if (wcount < NMAX) wstore[wcount] = w[31:0];
          wsum = wsum + w;
          if (wcount < 2047) wcount++;
          if (it.fin) begin
            fresh = (it.seq > acc_seq) || (acc_seq >= SEQ_HALF && it.seq < SEQ_HALF);
            if (!fresh) st = ST_STALE;
            else if (!(cfg_count >= 1 && cfg_count <= NMAX && wcount == cfg_count))
              st = ST_SIZE;
            wcount = 0;
            if (st == ST_OK) begin
              armed = 1'b1;
              dcount = 0;
              mean_acc[0] = 0; mean_acc[1] = 0; mean_acc[2] = 0;
            end else begin
              wsum = '0;
            end
          end
          expected_results.push_back(status_result(st));
        end
      end
      CMD_DRAW: begin
        if (!armed) begin
          expected_results.push_back(status_result(ST_UNEXPECTED));
        end else begin
          n = (cfg_count < 1) ? 1 : (cfg_count > NMAX) ? NMAX : cfg_count;
          thr = 64'(it.draw) * (wsum >> 24) + ((64'(it.draw) * (wsum & 64'hFF_FFFF)) >> 24);
          cum = '0;
          j = 0;
          hit = 1'b0;
          while (!hit && j + 1 < n) begin
            cum = cum + 64'(wstore[j]);
            if (cum > thr) hit = 1'b1;
            else j++;
          end
          p = bank[act_bank][j];
          bank[~act_bank][dcount] = p;
          mean_acc[0] += longint'(p.x);
          mean_acc[1] += longint'(p.y);
          mean_acc[2] += longint'(p.h);
          r = '{KIND_SELECT, ST_OK, 10'(dcount), 10'(j), p.x, p.y, p.h, 1'b0};
          if (dcount + 1 < n) begin
            dcount++;
            r.run_end = 1'b1;
            expected_results.push_back(r);
          end else begin
            expected_results.push_back(r);
            r = '{KIND_MEAN, ST_OK, 10'd0, 10'd0,
                  32'(mean_acc[0] / longint'(n)), 32'(mean_acc[1] / longint'(n)),
                  16'(mean_acc[2] / longint'(n)), 1'b1};
            expected_results.push_back(r);
            act_bank = ~act_bank;
            armed = 1'b0;
            dcount = 0;
            wsum = '0;
            acc_seq = set_seq + 1;
            set_seq = set_seq + 1;
            resamples++;
          end
        end
      end
      default: expected_results.push_back(status_result(ST_UNEXPECTED));
    endcase
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        predict_item(cur_item);
        txn_in++;
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        cur_item = pending_items.pop_front();
        command <= cur_item.command;
        slot <= cur_item.slot;
        pose_x <= cur_item.x;
        pose_y <= cur_item.y;
        pose_heading <= cur_item.h;
        likelihood <= cur_item.lik;
        batch_seq <= cur_item.seq;
        final_item <= cur_item.fin;
        draw <= cur_item.draw;
        in_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_left == 0) begin
      out_ready <= ~out_ready;
      if (out_ready) hold_left <= $urandom_range(0, 6);
      else hold_left <= ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 30);
    end else begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic report(string field, longint got, longint want);
    $display("mismatch at %0t on %s: got %0h expected %0h", $time, field, got, want);
    errors++;
  endtask

  // monitor
  always @(posedge clk) begin
    result_t e;
    if (!rst && out_valid && out_ready) begin
      txn_out++;
      if (expected_results.size() == 0) begin
        report("unexpected transaction", kind, 0);
      end else begin
        e = expected_results.pop_front();
        if (kind != e.kind) report("kind", kind, e.kind);
        if (status != e.status) report("status", status, e.status);
        if (new_slot != e.new_slot) report("new_slot", new_slot, e.new_slot);
        if (source_slot != e.source_slot) report("source_slot", source_slot, e.source_slot);
        if (out_x != e.x) report("out_x", out_x, e.x);
        if (out_y != e.y) report("out_y", out_y, e.y);
        if (out_heading != e.h) report("out_heading", out_heading, e.h);
        if (run_end != e.run_end) report("run_end", run_end, e.run_end);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", expected_results.size());
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_PARTICLE_COUNT: cfg_count = val[10:0];
      CFG_WEIGHT_FLOOR:   cfg_floor = val;
      CFG_UNIFORM_WEIGHT: cfg_uniform = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic add_item(logic [1:0] cmd, logic [9:0] s, logic f,
                          logic [31:0] lk, logic [31:0] sq, logic [23:0] d);
    item_t it;
    it.command = cmd;
    it.slot = s;
    it.x = $urandom;
    it.y = $urandom;
    it.h = $urandom;
    it.lik = lk;
    it.seq = sq;
    it.fin = f;
    it.draw = d;
    pending_items.push_back(it);
  endtask

  function automatic logic [31:0] fresh_seq();
    logic [31:0] s;
    s = $urandom;
    if (s <= acc_seq) s = acc_seq + 1 + $urandom_range(0, 100);
    return s;
  endfunction

  function automatic logic [31:0] rand_lik();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 32'h0100_0000);
      default: return $urandom;
    endcase
  endfunction

  // well-formed pose set, weight batch and n draws; noisy runs mix in stray commands
  task automatic resample_run(int n, bit noisy);
    for (int i = 0; i < n; i++) add_item(CMD_POSE, 10'(i), i == n - 1, $urandom, $urandom, $urandom);
    drain();
    for (int i = 0; i < n; i++)
      add_item(CMD_WEIGHT, $urandom, i == n - 1, rand_lik(), fresh_seq(), $urandom);
    for (int i = 0; i < n; i++) begin
      if (noisy && $urandom_range(0, 5) == 0)
        add_item($urandom_range(0, 1) ? CMD_POSE : CMD_WEIGHT, $urandom, $urandom, $urandom,
                 $urandom, $urandom);
      if (noisy && $urandom_range(0, 9) == 0)
        add_item(2'd3, $urandom, $urandom, $urandom, $urandom, $urandom);
      add_item(CMD_DRAW, $urandom, $urandom, $urandom, $urandom, $urandom);
    end
    drain();
  endtask

  initial begin
    int n;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: draw not armed, unused command, short batch is a size mismatch, zero seq stale
    add_item(CMD_DRAW, 0, 0, 0, 0, 24'hFF_FFFF);
    add_item(2'd3, 0, 0, 0, 0, 0);
    add_item(CMD_WEIGHT, 0, 0, 32'hFFFF_FFFF, 0, 0);
    add_item(CMD_WEIGHT, 0, 1, 0, 32'hFFFF_FFFF, 0);
    add_item(CMD_WEIGHT, 0, 1, 32'h1234_5678, 32'd0, 0);
    drain();

    // single particle at the extremes of floor and prior
    write_reg(CFG_PARTICLE_COUNT, 25'd1);
    write_reg(CFG_WEIGHT_FLOOR, 25'd0);
    write_reg(CFG_UNIFORM_WEIGHT, 25'h100_0000);
    resample_run(1, 0);
    // stale batch with the sequence just accepted
    add_item(CMD_WEIGHT, 0, 1, 32'd5, acc_seq, 0);
    drain();
    write_reg(CFG_WEIGHT_FLOOR, 25'h100_0000);
    write_reg(CFG_UNIFORM_WEIGHT, 25'd0);
    add_item(CMD_POSE, 10'h3FF, 1, 0, 0, 0);
    resample_run(1, 0);

    // zero and oversized counts never match
    write_reg(CFG_PARTICLE_COUNT, 25'd0);
    add_item(CMD_WEIGHT, 0, 1, 1, fresh_seq(), 0);
    drain();
    write_reg(CFG_PARTICLE_COUNT, 25'd2047);
    add_item(CMD_WEIGHT, 0, 0, 1, 0, 0);
    add_item(CMD_WEIGHT, 0, 1, 1, fresh_seq(), 0);
    drain();

    // draw extremes on a two-particle set
    write_reg(CFG_PARTICLE_COUNT, 25'd2);
    write_reg(CFG_WEIGHT_FLOOR, WEIGHT_FLOOR_RST);
    write_reg(CFG_UNIFORM_WEIGHT, UNIFORM_WEIGHT_RST);
    add_item(CMD_POSE, 0, 0, 0, 0, 0);
    add_item(CMD_POSE, 1, 1, 0, 0, 0);
    drain();
    add_item(CMD_WEIGHT, 0, 0, 32'h0100_0000, fresh_seq(), 0);
    add_item(CMD_WEIGHT, 0, 1, 32'h0300_0000, fresh_seq(), 0);
    add_item(CMD_DRAW, 0, 0, 0, 0, 24'd0);
    add_item(CMD_DRAW, 0, 0, 0, 0, 24'hFF_FFFF);
    drain();

    write_reg(CFG_PARTICLE_COUNT, 25'd32);
    resample_run(32, 1);

    while (txn_in < 580) begin
      if ($urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, 12);
        write_reg(CFG_PARTICLE_COUNT, 25'(n));
        write_reg(CFG_WEIGHT_FLOOR, ($urandom_range(0, 3) == 0) ?
                  25'($urandom_range(0, 25'h100_0000)) : 25'($urandom_range(0, 64)));
        write_reg(CFG_UNIFORM_WEIGHT, ($urandom_range(0, 4) == 0) ?
                  25'h100_0000 : 25'($urandom_range(0, 25'h100_0000)));
      end
      n = cfg_count;
      if ($urandom_range(0, 3) != 0) begin
        resample_run(n, 1);
      end else begin
        // possibly broken batch: length may be wrong, sequence stale or random
        for (int i = 0; i < n + $urandom_range(0, 3) - 1 || i == 0; i++)
          add_item(CMD_WEIGHT, $urandom, 1'b0, rand_lik(), $urandom, $urandom);
        add_item(CMD_WEIGHT, $urandom, 1'b1, rand_lik(),
                 $urandom_range(0, 1) ? acc_seq : $urandom, $urandom);
        add_item(CMD_DRAW, $urandom, $urandom, $urandom, $urandom, $urandom);
        drain();
      end
    end
    drain();
    repeat (200) @(posedge clk);

    $display("%0d input and %0d output transactions, %0d completed resampling runs",
             txn_in, txn_out, resamples);
    $display("%0d mismatches, %0d results left outstanding", errors, expected_results.size());
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/pwr_pkg.sv
rtl/particle_weight_resampler_unit.sv
tb/sv/tb.sv
